// ===== rtl/bf2d_pkg.sv =====
// ----------------------------------------------------------------------------
// Box filter package
// Shared beat types, register indexes and defaults of the 2D box filter.
// ----------------------------------------------------------------------------
package bf2d_pkg;

  localparam int DefMaxWidth    = 1024;
  localparam int DefMaxRadius   = 7;
  localparam int DefMaxChannels = 4;

  localparam int LeadMax     = 4;
  localparam int StoreMargin = 8;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       frame_last;
  } out_beat_t;

  typedef struct packed {
    logic [10:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    logic [2:0]  radius;
    logic [12:0] row_len;
  } frame_cfg_t;

  typedef struct packed {
    logic [15:0] row;
    logic [10:0] pixel;
    logic        last;
  } job_t;

endpackage

// ===== rtl/bf2d_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module bf2d_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bf2d_front.sv =====
// ----------------------------------------------------------------------------
// Box filter front
// Holds the registers, writes samples to the store and issues output jobs.
// ----------------------------------------------------------------------------
module bf2d_front #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_RADIUS   = 7,
  parameter int MAX_CHANNELS = 4,
  parameter int PD           = 61448,
  parameter int AW           = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bf2d_pkg::in_beat_t    in_data,
  input  logic                  q_full,
  input  logic                  pending,
  output logic                  push,
  output bf2d_pkg::job_t        push_job,
  output logic [AW-1:0]         push_ptr,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [7:0]            wr_data,
  output bf2d_pkg::frame_cfg_t  cfg
);

  import bf2d_pkg::*;

  logic [10:0] cfg_w;
  logic [15:0] cfg_h;
  logic [2:0]  cfg_c;
  logic [2:0]  cfg_r;

  logic [10:0] w_e;
  logic [15:0] h_e;
  logic [2:0]  c_e;
  logic [2:0]  r_e;
  logic [12:0] wc;

  logic [12:0]   in_col, in_col_next;
  logic [15:0]   in_row, in_row_next;
  logic [AW-1:0] in_ptr, in_ptr_next;
  logic [12:0]   out_col;
  logic [15:0]   out_row;
  logic [10:0]   px;
  logic [2:0]    ch;
  logic [AW-1:0] out_ptr;
  logic [2:0]    lead;

  logic        accept;
  logic        do_write;
  logic [16:0] row_sum;
  logic [15:0] need_row;
  logic [11:0] px_sum;
  logic [10:0] need_px;
  logic [12:0] need_col;
  logic        last;

  always_comb begin
    if (cfg_w == 11'd0) begin
      w_e = 11'd1;
    end else if (14'(cfg_w) > 14'(MAX_WIDTH)) begin
      w_e = 11'(MAX_WIDTH);
    end else begin
      w_e = cfg_w;
    end
    h_e = (cfg_h == 16'd0) ? 16'd1 : cfg_h;
    if (cfg_c == 3'd0) begin
      c_e = 3'd1;
    end else if (cfg_c > 3'(MAX_CHANNELS)) begin
      c_e = 3'(MAX_CHANNELS);
    end else begin
      c_e = cfg_c;
    end
    r_e = (4'(cfg_r) > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : cfg_r;
    wc  = 13'(w_e) * 13'(c_e);
  end

  assign cfg = '{width: w_e, height: h_e, channels: c_e, radius: r_e, row_len: wc};

  assign in_ready = !q_full && (lead < 3'(LeadMax));
  assign accept   = in_valid && in_ready;
  assign do_write = accept && !in_data.operation && (in_row < h_e);

  always_comb begin
    in_col_next = in_col;
    in_row_next = in_row;
    in_ptr_next = in_ptr;
    if (do_write) begin
      in_ptr_next = (in_ptr == AW'(PD - 1)) ? '0 : in_ptr + 1'b1;
      if (in_col == wc - 13'd1) begin
        in_col_next = '0;
        in_row_next = in_row + 16'd1;
      end else begin
        in_col_next = in_col + 13'd1;
      end
    end
    row_sum  = {1'b0, out_row} + 17'(r_e);
    need_row = (row_sum > {1'b0, h_e - 16'd1}) ? h_e - 16'd1 : row_sum[15:0];
    px_sum   = {1'b0, px} + 12'(r_e);
    need_px  = (px_sum > {1'b0, w_e - 11'd1}) ? w_e - 11'd1 : px_sum[10:0];
    need_col = 13'(need_px) * 13'(c_e) + 13'(ch);
    push = accept && (out_row < h_e) &&
           ((in_row_next > need_row) ||
            ((in_row_next == need_row) && (in_col_next > need_col)));
    last = (out_row == h_e - 16'd1) && (out_col == wc - 13'd1);
  end

  assign push_job = '{row: out_row, pixel: px, last: last};
  assign push_ptr = out_ptr;
  assign wr_en    = do_write;
  assign wr_addr  = in_ptr;
  assign wr_data  = in_data.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w   <= 11'd1024;
      cfg_h   <= 16'd1024;
      cfg_c   <= 3'd3;
      cfg_r   <= 3'd1;
      in_col  <= '0;
      in_row  <= '0;
      in_ptr  <= '0;
      out_col <= '0;
      out_row <= '0;
      px      <= '0;
      ch      <= '0;
      out_ptr <= '0;
      lead    <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg_w <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT:  cfg_h <= cfg_data;
        CFG_CHANNEL_COUNT: cfg_c <= cfg_data[2:0];
        CFG_WINDOW_RADIUS: cfg_r <= cfg_data[2:0];
        default: cfg_w <= cfg_w;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      px      <= '0;
      ch      <= '0;
      out_ptr <= in_ptr;
      lead    <= '0;
    end else begin
      lead <= pending ? lead + 3'(do_write) : '0;
      if (accept) begin
        in_col <= in_col_next;
        in_row <= in_row_next;
        in_ptr <= in_ptr_next;
        if (push) begin
          if (last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
            px      <= '0;
            ch      <= '0;
            out_ptr <= in_ptr_next;
          end else begin
            out_ptr <= (out_ptr == AW'(PD - 1)) ? '0 : out_ptr + 1'b1;
            if (out_col == wc - 13'd1) begin
              out_col <= '0;
              out_row <= out_row + 16'd1;
              px      <= '0;
              ch      <= '0;
            end else begin
              out_col <= out_col + 13'd1;
              if (ch == c_e - 3'd1) begin
                ch <= '0;
                px <= px + 11'd1;
              end else begin
                ch <= ch + 3'd1;
              end
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/bf2d_back.sv =====
// ----------------------------------------------------------------------------
// Box filter back
// Sums the clamped window from the sample store and divides by its size.
// ----------------------------------------------------------------------------
module bf2d_back #(
  parameter int PD = 61448,
  parameter int AW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bf2d_pkg::frame_cfg_t  cfg,
  input  logic                  q_valid,
  input  bf2d_pkg::job_t        q_job,
  input  logic [AW-1:0]         q_ptr,
  output logic                  q_pop,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [7:0]            wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bf2d_pkg::out_beat_t   out_data,
  output logic                  busy
);

  import bf2d_pkg::*;

  localparam int OW = AW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [7:0] mem [PD];

  logic [2:0]    state;
  logic [AW-1:0] base;
  logic          last;
  logic [2:0]    ylo, yhi, xlo, xhi;
  logic signed [4:0] dy, dx;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic [15:0]   sum;
  logic [15:0]   quo;
  logic [8:0]    rem;
  logic [4:0]    cnt;

  logic signed [4:0]    r_s;
  logic signed [4:0]    ycl, xcl;
  logic signed [OW-1:0] yv, xv, wcs, cs, off, tgt;
  logic [15:0]   row_room;
  logic [10:0]   px_room;
  logic [3:0]    side;
  logic [7:0]    divisor;
  logic [8:0]    rem_sh;
  logic [AW-1:0] addr_next;

  assign r_s     = $signed({2'b00, cfg.radius});
  assign side    = {cfg.radius, 1'b1};
  assign divisor = 8'(side) * 8'(side);
  assign rem_sh  = {rem[7:0], quo[15]};
  assign row_room = cfg.height - 16'd1 - q_job.row;
  assign px_room  = cfg.width - 11'd1 - q_job.pixel;

  always_comb begin
    if (dy < -$signed({2'b00, ylo})) begin
      ycl = -$signed({2'b00, ylo});
    end else if (dy > $signed({2'b00, yhi})) begin
      ycl = $signed({2'b00, yhi});
    end else begin
      ycl = dy;
    end
    if (dx < -$signed({2'b00, xlo})) begin
      xcl = -$signed({2'b00, xlo});
    end else if (dx > $signed({2'b00, xhi})) begin
      xcl = $signed({2'b00, xhi});
    end else begin
      xcl = dx;
    end
    yv  = OW'(ycl);
    xv  = OW'(xcl);
    wcs = OW'(cfg.row_len);
    cs  = OW'(cfg.channels);
    off = yv * wcs + xv * cs;
    tgt = $signed(OW'(base)) + off;
    if (tgt < 0) begin
      addr_next = AW'(tgt + $signed(OW'(PD)));
    end else if (tgt >= $signed(OW'(PD))) begin
      addr_next = AW'(tgt - $signed(OW'(PD)));
    end else begin
      addr_next = AW'(tgt);
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign busy      = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{mean_value: quo[7:0], frame_last: last};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            base  <= q_ptr;
            last  <= q_job.last;
            ylo   <= (q_job.row < 16'(cfg.radius)) ? q_job.row[2:0] : cfg.radius;
            yhi   <= (row_room < 16'(cfg.radius)) ? row_room[2:0] : cfg.radius;
            xlo   <= (q_job.pixel < 11'(cfg.radius)) ? q_job.pixel[2:0] : cfg.radius;
            xhi   <= (px_room < 11'(cfg.radius)) ? px_room[2:0] : cfg.radius;
            dy    <= -r_s;
            dx    <= -r_s;
            sum   <= '0;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          rd_addr <= addr_next;
          state   <= S_READ;
        end
        S_READ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum + 16'(rdata);
          if (dx == r_s) begin
            dx <= -r_s;
            if (dy == r_s) begin
              quo   <= sum + 16'(rdata);
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end else begin
              dy    <= dy + 5'sd1;
              state <= S_ADDR;
            end
          end else begin
            dx    <= dx + 5'sd1;
            state <= S_ADDR;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, divisor}) begin
            rem <= rem_sh - {1'b0, divisor};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[14:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/box_filter_2d_interleaved_unit.sv =====
// ----------------------------------------------------------------------------
// 2D box filter, interleaved channels
// Mean of the clamped square window around every sample of a raster frame.
// ----------------------------------------------------------------------------
// Samples are taken in one cycle each and written to the sample store while
// the job queue has room, but no more than four samples are written while a
// result is still queued or being computed, which keeps the write pointer clear
// of every window still being read. Each result is computed by the back end,
// which reads the store through its one read port once per window tap, going
// through S_ADDR, S_READ and S_ACC for each tap, and then runs a sixteen-step
// divider; its beat then waits for out_ready. The store needs no clearing pass
// after reset.
module box_filter_2d_interleaved_unit #(
  parameter int MAX_WIDTH    = bf2d_pkg::DefMaxWidth,
  parameter int MAX_RADIUS   = bf2d_pkg::DefMaxRadius,
  parameter int MAX_CHANNELS = bf2d_pkg::DefMaxChannels
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bf2d_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bf2d_pkg::out_beat_t  out_data
);

  import bf2d_pkg::*;

  localparam int PD = (2 * MAX_RADIUS + 1) * MAX_WIDTH * MAX_CHANNELS + StoreMargin;
  localparam int AW = $clog2(PD);
  localparam int JW = $bits(job_t) + AW;

  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          push;
  job_t          push_job;
  logic [AW-1:0] push_ptr;
  job_t          q_job;
  logic [AW-1:0] q_ptr;
  logic [JW-1:0] q_out;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  frame_cfg_t    cfg;
  logic          back_busy;
  logic          pending;

  assign pending = q_valid || back_busy;
  assign q_job   = q_out[JW-1:AW];
  assign q_ptr   = q_out[AW-1:0];

  bf2d_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .MAX_CHANNELS(MAX_CHANNELS),
    .PD(PD), .AW(AW)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_full(q_full), .pending(pending),
    .push(push), .push_job(push_job), .push_ptr(push_ptr),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .cfg(cfg)
  );

  bf2d_queue #(.WIDTH(JW), .DEPTH(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data({push_job, push_ptr}),
    .full(q_full), .valid(q_valid),
    .pop(q_pop), .pop_data(q_out)
  );

  bf2d_back #(.PD(PD), .AW(AW)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_job(q_job), .q_ptr(q_ptr), .q_pop(q_pop),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .busy(back_busy)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job issued into a full queue");
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> back_busy)
    else $error("result beat shown while the back end is idle");
  a_reset_empty: assert property (@(posedge clk) rst |=> !q_valid && !out_valid)
    else $error("queue or output not empty after reset");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
      !in_ready && !q_full |-> pending || $past(pending))
    else $error("input stalled with no job pending");
`endif

endmodule
